### design/trace_header_parser_core_assert.svh
// Assertion macros for the traceparent header parser.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef TRACE_HEADER_PARSER_CORE_ASSERT_SVH
`define TRACE_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define THP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define THP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/thp_pkg.sv
// Shared types and constants of the traceparent header parser.
// No dependencies.
package thp_pkg;

  // Byte positions within the header
  localparam logic [7:0] VERSION_DASH_POS = 8'd2;
  localparam logic [7:0] TRACE_START      = 8'd3;
  localparam logic [7:0] SPAN_DIGITS      = 8'd16;
  localparam logic [7:0] TRACE_SPLIT      = 8'(TRACE_START + SPAN_DIGITS);
  localparam logic [7:0] TRACE_DASH_POS   = 8'd35;
  localparam logic [7:0] SPAN_DASH_POS    = 8'd52;
  localparam logic [7:0] FLAGS_START      = 8'd53;
  localparam int unsigned MIN_LENGTH      = 55;
  // pos + 1 < MIN_LENGTH  <=>  pos < SHORT_LIMIT
  localparam logic [7:0] SHORT_LIMIT      = 8'(MIN_LENGTH - 1);
  localparam logic [7:0] POS_MAX          = 8'hFF;

  localparam int unsigned FLAG_W  = 31;
  localparam int unsigned WORD_W  = 64;
  localparam int unsigned RES_W   = 3 + 3 * WORD_W + FLAG_W;
  localparam int unsigned TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PAD_W   = TDATA_W - RES_W;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_VERSION = 3'd2,
    ST_TRACE   = 3'd3,
    ST_SPAN    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FP_SKIP   = 2'd0,
    FP_DIGITS = 2'd1,
    FP_DONE   = 2'd2
  } flag_phase_e;

  typedef struct packed {
    logic [FLAG_W-1:0] flag_bits;
    logic [WORD_W-1:0] span_word;
    logic [WORD_W-1:0] trace_lower;
    logic [WORD_W-1:0] trace_upper;
    status_e           status;
  } thp_result_t;

endpackage

### design/trace_header_parser_core.sv
// Traceparent header parser: header bytes in on a slave stream, one parsed
//   result per header out on a master stream.
// Slave side: tdata[7:0] is one header byte, tlast marks the final byte.
//   Every byte is a transfer; only the final byte of a header gives a result.
// Master side: tdata carries status, trace id halves, span id and flags.
//   Status 0 ok, 1 short header, 2 bad version, 3 bad trace id, 4 bad span id;
//   all value fields read zero whenever the status is not ok.
// Result path: the final byte passes the input register, then the parse logic,
//   then the result register, which raises m_axis_tvalid_o; while the result
//   register is full, the final byte is held in the input register.
// Throughput: one byte per cycle, set by the single parse stage, unless a final
//   byte waits on a full result register; headers may follow back to back.
// Stall: while a result waits on m_axis_tready_i, bytes that give no result
//   still flow into the parse state; a final byte waits in the input register
//   until the result register frees, and s_axis_tready_o stays low meanwhile.
// Reset: rst_ni clears all valid flags and the parse state; the first byte
//   after reset is byte 0 of a header.
// Depends on thp_pkg, thp_in_reg, thp_parse, thp_out_reg and the assertion
//   macro header.
`include "trace_header_parser_core_assert.svh"

module trace_header_parser_core
  import thp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] header_byte
  input  logic               s_axis_tlast_i,   // end_of_header
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [2:0] parse_status, [66:3] trace_upper, [130:67] trace_lower,
  // [194:131] span_word, [225:195] flag_bits, [231:226] zero
  output logic [TDATA_W-1:0] m_axis_tdata_o
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_free;
  logic        advance;
  thp_result_t parse_res;
  thp_result_t out_res;

  // a byte with no result always moves on; a final byte needs room downstream
  assign advance = in_valid && (!in_last || out_free);

  thp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .byte_i    (s_axis_tdata_i),
    .last_i    (s_axis_tlast_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .last_o    (in_last)
  );

  thp_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .byte_i   (in_byte),
    .last_i   (in_last),
    .result_o (parse_res)
  );

  thp_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && in_last),
    .result_i (parse_res),
    .free_o   (out_free),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .result_o (out_res)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, out_res};

  `THP_ASSERT_IMP(a_err_zero, m_axis_tvalid_o && out_res.status != ST_OK,
    out_res.trace_upper == '0 && out_res.trace_lower == '0 && out_res.span_word == '0
    && out_res.flag_bits == '0, "value fields not zero on error status")
  `THP_ASSERT_IMP(a_status_range, m_axis_tvalid_o,
    out_res.status == ST_OK || out_res.status == ST_SHORT || out_res.status == ST_VERSION
    || out_res.status == ST_TRACE || out_res.status == ST_SPAN, "status code out of range")
  `THP_ASSERT_IMP(a_result_from_last, $rose(m_axis_tvalid_o),
    $past(advance && in_last), "result appeared without a final byte")
  `THP_ASSERT_NXT(a_last_held, in_valid && in_last && !out_free,
    in_valid && in_last, "final byte dropped while the result register was full")

endmodule

### design/thp_in_reg.sv
// Input register of the traceparent header parser: holds one byte transfer.
// Depends on thp_pkg.
module thp_in_reg
  import thp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;

  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
      last_q <= last_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

endmodule

### design/thp_parse.sv
// Per-byte parse logic and accumulator state of the traceparent header parser.
// Depends on thp_pkg.
module thp_parse
  import thp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        fire_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output thp_result_t result_o
);

  logic [7:0]        pos_q, pos_d;
  logic [WORD_W-1:0] th_q, th_d, tl_q, tl_d, sp_q, sp_d;
  logic [FLAG_W-1:0] fl_q, fl_d;
  flag_phase_e       ph_q, ph_d;
  logic              ovf_q, ovf_d;
  status_e           fault_q, fault_d;

  logic       hex_ok;
  logic [3:0] nib;
  logic       blank;
  status_e    code;
  status_e    status;

  always_comb begin
    hex_ok = 1'b1;
    nib    = 4'd0;
    if (byte_i >= "0" && byte_i <= "9") begin
      nib = 4'(byte_i - "0");
    end else if (byte_i >= "a" && byte_i <= "f") begin
      nib = 4'(byte_i - "a" + 8'd10);
    end else if (byte_i >= "A" && byte_i <= "F") begin
      nib = 4'(byte_i - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign blank = (byte_i == " ") || (byte_i >= 8'd9 && byte_i <= 8'd13);

  always_comb begin
    th_d  = th_q;
    tl_d  = tl_q;
    sp_d  = sp_q;
    fl_d  = fl_q;
    ph_d  = ph_q;
    ovf_d = ovf_q;
    code  = ST_OK;
    if (pos_q < VERSION_DASH_POS) begin
      if (byte_i != "0") code = ST_VERSION;
    end else if (pos_q == VERSION_DASH_POS) begin
      if (byte_i != "-") code = ST_VERSION;
    end else if (pos_q < TRACE_DASH_POS) begin
      if (!hex_ok) begin
        code = ST_TRACE;
      end else if (pos_q < TRACE_SPLIT) begin
        th_d = {th_q[WORD_W-5:0], nib};
      end else begin
        tl_d = {tl_q[WORD_W-5:0], nib};
      end
    end else if (pos_q == TRACE_DASH_POS) begin
      if (byte_i != "-") code = ST_TRACE;
    end else if (pos_q < SPAN_DASH_POS) begin
      if (!hex_ok) code = ST_SPAN;
      else sp_d = {sp_q[WORD_W-5:0], nib};
    end else if (pos_q == SPAN_DASH_POS) begin
      if (byte_i != "-") code = ST_SPAN;
    end else if (ph_q == FP_SKIP && blank) begin
      // leading whitespace before the flags
    end else if (ph_q != FP_DONE) begin
      if (!hex_ok) begin
        ph_d = FP_DONE;
      end else begin
        ph_d = FP_DIGITS;
        if (!ovf_q) begin
          // acc*16 + d fits in 31 bits exactly when the top nibble is clear
          if (fl_q[FLAG_W-1:FLAG_W-4] != 4'd0) ovf_d = 1'b1;
          else fl_d = {fl_q[FLAG_W-5:0], nib};
        end
      end
    end
    fault_d = (fault_q == ST_OK) ? code : fault_q;
    pos_d   = (pos_q == POS_MAX) ? pos_q : pos_q + 8'd1;
  end

  always_comb begin
    status = (pos_q < SHORT_LIMIT) ? ST_SHORT : fault_d;
    result_o.status = status;
    if (status == ST_OK) begin
      result_o.trace_upper = th_d;
      result_o.trace_lower = tl_d;
      result_o.span_word   = sp_d;
      result_o.flag_bits   = (ph_d == FP_SKIP || ovf_d) ? '0 : fl_d;
    end else begin
      result_o.trace_upper = '0;
      result_o.trace_lower = '0;
      result_o.span_word   = '0;
      result_o.flag_bits   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      th_q    <= '0;
      tl_q    <= '0;
      sp_q    <= '0;
      fl_q    <= '0;
      ph_q    <= FP_SKIP;
      ovf_q   <= 1'b0;
      fault_q <= ST_OK;
    end else if (fire_i) begin
      if (last_i) begin
        // header complete: start afresh
        pos_q   <= '0;
        th_q    <= '0;
        tl_q    <= '0;
        sp_q    <= '0;
        fl_q    <= '0;
        ph_q    <= FP_SKIP;
        ovf_q   <= 1'b0;
        fault_q <= ST_OK;
      end else begin
        pos_q   <= pos_d;
        th_q    <= th_d;
        tl_q    <= tl_d;
        sp_q    <= sp_d;
        fl_q    <= fl_d;
        ph_q    <= ph_d;
        ovf_q   <= ovf_d;
        fault_q <= fault_d;
      end
    end
  end

endmodule

### design/thp_out_reg.sv
// Result register of the traceparent header parser, driving the master stream.
// Depends on thp_pkg.
module thp_out_reg
  import thp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  thp_result_t result_i,
  output logic        free_o,
  output logic        valid_o,
  input  logic        ready_i,
  output thp_result_t result_o
);

  logic        valid_q;
  thp_result_t result_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) result_q <= result_i;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule
